### rtl/core/pbpm_pkg.sv
// Shared types and constants of the packet buffer pool manager.
package pbpm_pkg;

   // Width of a slot index as it travels on the request and result channels.
   localparam int SLOT_WIDTH = 4;

   // Request codes.
   typedef enum logic [1:0] {
      OP_GET_EMPTY = 2'd0,
      OP_GET_FULL  = 2'd1,
      OP_PUT_EMPTY = 2'd2,
      OP_PUT_FULL  = 2'd3
   } op_type;

   // Commands from the controller to the datapath, one step per cycle.
   typedef struct packed {
      logic init_wr;   // write one entry of the reset chain
      logic accept;    // latch an incoming item
      logic pop;       // pop the head of the selected list
      logic steal;     // pop the tail of the full list
      logic clear;     // null the forward link of the stolen slot
      logic push;      // write the links of the pushed slot
      logic link;      // point the old head back at the pushed slot
      logic finish;    // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;          // latched request code
      logic   slot_ok;     // latched slot index lies inside the pool
      logic   empty_has;   // empty list holds a slot
      logic   full_has;    // full list holds a slot
      logic   head_has;    // list selected by the request holds a slot
      logic   init_last;   // last entry of the reset chain is being written
      logic   rsp_free;    // result register can take a new item
   } stat_type;

endpackage

### rtl/core/pbpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pbpm_ctrl.sv
// Controller state machine of the packet buffer pool manager.
module pbpm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pbpm_pkg::stat_type stat,
   output pbpm_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READ  = 9'b000000100,
      ST_POP   = 9'b000001000,
      ST_STEAL = 9'b000010000,
      ST_CLEAR = 9'b000100000,
      ST_PUSH  = 9'b001000000,
      ST_LINK  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      is_put;

   assign is_put = (stat.op == pbpm_pkg::OP_PUT_EMPTY) || (stat.op == pbpm_pkg::OP_PUT_FULL);

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            // The link read issued here is ready in the next cycle.
            if (is_put) begin
               state_in = stat.slot_ok ? ST_PUSH : ST_DONE;
            end else if (stat.op == pbpm_pkg::OP_GET_EMPTY) begin
               if (stat.empty_has) begin
                  state_in = ST_POP;
               end else if (stat.full_has) begin
                  state_in = ST_STEAL;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = stat.full_has ? ST_POP : ST_DONE;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_DONE;
         end
         ST_STEAL: begin
            cmd.steal = 1'b1;
            state_in  = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_DONE;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = stat.head_has ? ST_LINK : ST_DONE;
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/pbpm_datapath.sv
// List pointers, link memories and result register of the pool manager.
module pbpm_datapath #(
   parameter int SLOT_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  pbpm_pkg::cmd_type  cmd,
   output pbpm_pkg::stat_type stat,
   input  logic [7:0]         req_tdata,
   input  logic [1:0]         req_tuser,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   localparam int LW = $clog2(SLOT_COUNT + 1);
   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SW = pbpm_pkg::SLOT_WIDTH;
   localparam logic [LW-1:0] LINK_NULL = LW'(SLOT_COUNT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);

   // List ends, request and result registers.
   logic [LW-1:0]        eh_ff, eh_in, et_ff, et_in;
   logic [LW-1:0]        fh_ff, fh_in, ft_ff, ft_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   pbpm_pkg::op_type     op_ff, op_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [LW-1:0]        got_ff, got_in;
   logic                 ow_ff, ow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]        rsp_slot_ff, rsp_slot_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 rsp_ow_ff, rsp_ow_in;

   // Link memory ports.
   logic                 nx_we, pv_we;
   logic [AW-1:0]        nx_waddr, pv_waddr, nx_raddr, pv_raddr;
   logic [LW-1:0]        nx_wdata, pv_wdata, nx_rdata, pv_rdata;

   logic                 sel_full;
   logic [LW-1:0]        head_sel;
   logic [LW-1:0]        slot_link;
   logic [LW-1:0]        cnt_link;
   logic                 is_get;

   assign sel_full  = (op_ff == pbpm_pkg::OP_GET_FULL) || (op_ff == pbpm_pkg::OP_PUT_FULL);
   assign is_get    = (op_ff == pbpm_pkg::OP_GET_EMPTY) || (op_ff == pbpm_pkg::OP_GET_FULL);
   assign head_sel  = sel_full ? fh_ff : eh_ff;
   assign slot_link = LW'(slot_ff);
   assign cnt_link  = LW'(cnt_ff);

   pbpm_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_next (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   pbpm_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_prev (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (pv_raddr),
      .rd_data (pv_rdata)
   );

   // Reads follow the selected head and the full tail at all times.
   assign nx_raddr = head_sel[AW-1:0];
   assign pv_raddr = ft_ff[AW-1:0];

   // Status toward the controller.
   always_comb begin
      stat.op        = op_ff;
      stat.slot_ok   = (32'(slot_ff) < SLOT_COUNT);
      stat.empty_has = (eh_ff < LINK_NULL);
      stat.full_has  = (ft_ff < LINK_NULL);
      stat.head_has  = (head_sel < LINK_NULL);
      stat.init_last = (cnt_ff == LAST_ADDR);
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // Link memory writes for each step.
   always_comb begin
      nx_we    = 1'b0;
      nx_waddr = cnt_ff;
      nx_wdata = LINK_NULL;
      pv_we    = 1'b0;
      pv_waddr = cnt_ff;
      pv_wdata = LINK_NULL;
      if (cmd.init_wr) begin
         // Chain left by pushing slots in rising order onto the empty list.
         nx_we    = 1'b1;
         nx_wdata = (cnt_ff == '0) ? LINK_NULL : cnt_link - LW'(1);
         pv_we    = 1'b1;
         pv_wdata = (cnt_ff == LAST_ADDR) ? LINK_NULL : cnt_link + LW'(1);
      end
      if (cmd.pop) begin
         pv_we    = (nx_rdata < LINK_NULL);
         pv_waddr = nx_rdata[AW-1:0];
      end
      if (cmd.steal) begin
         nx_we    = (pv_rdata < LINK_NULL);
         nx_waddr = pv_rdata[AW-1:0];
         pv_we    = 1'b1;
         pv_waddr = ft_ff[AW-1:0];
      end
      if (cmd.clear) begin
         nx_we    = 1'b1;
         nx_waddr = got_ff[AW-1:0];
      end
      if (cmd.push) begin
         nx_we    = 1'b1;
         nx_waddr = slot_link[AW-1:0];
         nx_wdata = head_sel;
         pv_we    = 1'b1;
         pv_waddr = slot_link[AW-1:0];
      end
      if (cmd.link) begin
         pv_we    = 1'b1;
         pv_waddr = head_sel[AW-1:0];
         pv_wdata = slot_link;
      end
   end

   // Next values of list ends, request and result registers.
   always_comb begin
      eh_in         = eh_ff;
      et_in         = et_ff;
      fh_in         = fh_ff;
      ft_in         = ft_ff;
      cnt_in        = cmd.init_wr ? cnt_ff + AW'(1) : cnt_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      got_in        = got_ff;
      ow_in         = ow_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ow_in     = rsp_ow_ff;
      if (cmd.accept) begin
         op_in   = pbpm_pkg::op_type'(req_tuser);
         slot_in = req_tdata[SW-1:0];
         got_in  = LINK_NULL;
         ow_in   = 1'b0;
      end
      if (cmd.pop) begin
         got_in = head_sel;
         if (sel_full) begin
            fh_in = nx_rdata;
            if (!(nx_rdata < LINK_NULL)) begin
               ft_in = LINK_NULL;
            end
         end else begin
            eh_in = nx_rdata;
            if (!(nx_rdata < LINK_NULL)) begin
               et_in = LINK_NULL;
            end
         end
      end
      if (cmd.steal) begin
         got_in = ft_ff;
         ow_in  = 1'b1;
         ft_in  = pv_rdata;
         if (!(pv_rdata < LINK_NULL)) begin
            fh_in = LINK_NULL;
         end
      end
      if (cmd.push) begin
         // A push onto an empty list makes the slot its head and tail here;
         // otherwise the head moves once the old head points back at it.
         if (sel_full) begin
            if (!(fh_ff < LINK_NULL)) begin
               fh_in = slot_link;
               ft_in = slot_link;
            end
         end else begin
            if (!(eh_ff < LINK_NULL)) begin
               eh_in = slot_link;
               et_in = slot_link;
            end
         end
      end
      if (cmd.link) begin
         if (sel_full) begin
            fh_in = slot_link;
         end else begin
            eh_in = slot_link;
         end
      end
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = is_get && !(got_ff < LINK_NULL);
         rsp_slot_in   = (is_get && (got_ff < LINK_NULL)) ? SW'(got_ff) : '0;
         rsp_ow_in     = ow_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         eh_ff        <= LW'(SLOT_COUNT - 1);
         et_ff        <= '0;
         fh_ff        <= LINK_NULL;
         ft_ff        <= LINK_NULL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eh_ff        <= eh_in;
         et_ff        <= et_in;
         fh_ff        <= fh_in;
         ft_ff        <= ft_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      got_ff        <= got_in;
      ow_ff         <= ow_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ow_ff     <= rsp_ow_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - SW){1'b0}}, rsp_slot_ff};
   assign rsp_tuser  = {rsp_ow_ff, rsp_status_ff};

endmodule

### rtl/core/packet_buffer_pool_manager_unit.sv
// Top level of the packet buffer pool manager: controller, datapath and checks.
//
// The pool of SLOT_COUNT buffer slots sits in two doubly linked lists, an
// empty list and a full list, that share one next-link and one prev-link
// memory. A request gets or puts one slot and always answers with one item.
// A get_empty takes the empty list's head, or steals the oldest full slot
// when no empty slot is left and flags that in the result; a get_full takes
// the newest full slot; a get with nothing to hand out returns status 1.
// Puts push onto the head of their list, and a put of an index outside the
// pool is dropped with an ok result. Requests are taken one at a time: a
// request is accepted in ST_IDLE, passes ST_READ, then ST_POP for a pop,
// ST_STEAL and ST_CLEAR for a steal, or ST_PUSH and, onto a non-empty
// list, ST_LINK for a push, and its result is loaded in ST_DONE, which a
// failed get or dropped put reaches from ST_READ; the steps are set by the
// registered read of the link memories and their single write port each.
// The next request is accepted in the cycle after the result is loaded,
// even while that result still waits to be taken. After reset the block
// writes the initial link chain and takes no request until it is done.
module packet_buffer_pool_manager_unit #(
   parameter int SLOT_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] slot_in, [7:4] zero
   input  logic [1:0] req_tuser,   // [1:0] op
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] slot_out, [7:4] zero
   output logic [1:0] rsp_tuser    // [0] status, [1] overwrote_full
);

   pbpm_pkg::cmd_type  cmd;
   pbpm_pkg::stat_type stat;

   pbpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pbpm_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // One request at a time: an accepted item closes the request side.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another item is in progress");

   // A failed get hands out no slot and reclaims nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> ((rsp_tdata[3:0] == 4'd0) && !rsp_tuser[1]))
      else $error("failed get carries a slot or an overwrite flag");

   // A new result is loaded only while the request side is closed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result item appeared without a request in progress");

endmodule

### dv/tb.sv
// Self-checking testbench for the packet buffer pool manager unit.
`timescale 1ns / 1ps

module tb;

   localparam int POOL_SLOTS = 16;
   localparam int EMPTY_LIST = 0;
   localparam int FULL_LIST  = 1;
   localparam int IDLE_PCT   = 28;

   typedef logic [4:0] link_type;
   localparam link_type LINK_NONE = link_type'(POOL_SLOTS);

   // One result item as the block should present it.
   typedef struct {
      logic [3:0] slot;
      logic       status;
      logic       overwrote;
   } pool_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [3:0] slot_in, [7:4] zero
   logic [1:0] req_tuser = 2'd0;   // [1:0] op
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [3:0] slot_out, [7:4] zero
   logic [1:0] rsp_tuser;          // [0] status, [1] overwrote_full

   // Shadow copy of the link store and the list ends.
   link_type next_of [POOL_SLOTS];
   link_type prev_of [POOL_SLOTS];
   link_type head_of [2];
   link_type tail_of [2];

   pool_rsp_type expected_rsp [$];
   logic [3:0]   held_slots [$];
   int           error_count = 0;
   logic         calm = 1'b0;

   packet_buffer_pool_manager_unit #(
      .SLOT_COUNT(POOL_SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit in_pool(link_type s);
      return s < link_type'(POOL_SLOTS);
   endfunction

   // Push a slot at the head of a list.
   function automatic void pool_push(int l, link_type s);
      next_of[s[3:0]] = head_of[l];
      prev_of[s[3:0]] = LINK_NONE;
      if (in_pool(head_of[l])) begin
         prev_of[head_of[l][3:0]] = s;
      end else begin
         tail_of[l] = s;
      end
      head_of[l] = s;
   endfunction

   // Pop the head of a list; LINK_NONE when the list is empty.
   function automatic link_type pool_pop_head(int l);
      link_type s;
      s = head_of[l];
      if (!in_pool(s)) return LINK_NONE;
      head_of[l] = next_of[s[3:0]];
      if (in_pool(head_of[l])) begin
         prev_of[head_of[l][3:0]] = LINK_NONE;
      end else begin
         tail_of[l] = LINK_NONE;
      end
      return s;
   endfunction

   // State after reset: slots 0 upward pushed in order onto the empty list.
   function automatic void pool_reset();
      for (int l = 0; l < 2; l++) begin
         head_of[l] = LINK_NONE;
         tail_of[l] = LINK_NONE;
      end
      for (int i = 0; i < POOL_SLOTS; i++) begin
         next_of[i] = LINK_NONE;
         prev_of[i] = LINK_NONE;
      end
      for (int i = 0; i < POOL_SLOTS; i++) pool_push(EMPTY_LIST, link_type'(i));
   endfunction

   // Apply one request to the shadow state and return the result it causes.
   function automatic pool_rsp_type pool_apply(pbpm_pkg::op_type op, logic [3:0] slot_in);
      pool_rsp_type r;
      link_type     got;
      link_type     s;
      got = LINK_NONE;
      r.slot = 4'd0;
      r.status = 1'b0;
      r.overwrote = 1'b0;
      case (op)
         pbpm_pkg::OP_GET_EMPTY: begin
            got = pool_pop_head(EMPTY_LIST);
            if (!in_pool(got)) begin
               // No empty slot left: reclaim the oldest full slot.
               s = tail_of[FULL_LIST];
               if (in_pool(s)) begin
                  tail_of[FULL_LIST] = prev_of[s[3:0]];
                  if (in_pool(tail_of[FULL_LIST])) begin
                     next_of[tail_of[FULL_LIST][3:0]] = LINK_NONE;
                  end else begin
                     head_of[FULL_LIST] = LINK_NONE;
                  end
                  next_of[s[3:0]] = LINK_NONE;
                  prev_of[s[3:0]] = LINK_NONE;
                  got = s;
                  r.overwrote = 1'b1;
               end
            end
         end
         pbpm_pkg::OP_GET_FULL: got = pool_pop_head(FULL_LIST);
         pbpm_pkg::OP_PUT_EMPTY: pool_push(EMPTY_LIST, link_type'(slot_in));
         default: pool_push(FULL_LIST, link_type'(slot_in));
      endcase
      if (op == pbpm_pkg::OP_GET_EMPTY || op == pbpm_pkg::OP_GET_FULL) begin
         if (in_pool(got)) r.slot = got[3:0];
         else r.status = 1'b1;
      end
      return r;
   endfunction

   // Send one request item; predict its result once it is accepted.
   task automatic send_request(pbpm_pkg::op_type op, logic [3:0] slot_in);
      pool_rsp_type r;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, slot_in};
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      r = pool_apply(op, slot_in);
      expected_rsp.push_back(r);
      if ((op == pbpm_pkg::OP_GET_EMPTY || op == pbpm_pkg::OP_GET_FULL) && !r.status) begin
         held_slots.push_back(r.slot);
      end
   endtask

   // Hand back a slot the client holds, or get one when it holds none.
   task automatic put_held(pbpm_pkg::op_type op);
      int idx;
      logic [3:0] s;
      if (held_slots.size() == 0) begin
         send_request(pbpm_pkg::OP_GET_EMPTY, 4'($urandom_range(15)));
      end else begin
         idx = $urandom_range(held_slots.size() - 1);
         s = held_slots[idx];
         held_slots.delete(idx);
         send_request(op, s);
      end
   endtask

   // One random request drawn by weight; noise is any op on any slot.
   task automatic random_request(int w_ge, int w_gf, int w_pe, int w_pf);
      int r;
      r = $urandom_range(99);
      if (r < w_ge) begin
         send_request(pbpm_pkg::OP_GET_EMPTY, 4'($urandom_range(15)));
      end else if (r < w_ge + w_gf) begin
         send_request(pbpm_pkg::OP_GET_FULL, 4'($urandom_range(15)));
      end else if (r < w_ge + w_gf + w_pe) begin
         put_held(pbpm_pkg::OP_PUT_EMPTY);
      end else if (r < w_ge + w_gf + w_pe + w_pf) begin
         put_held(pbpm_pkg::OP_PUT_FULL);
      end else begin
         send_request(pbpm_pkg::op_type'($urandom_range(3)), 4'($urandom_range(15)));
      end
   endtask

   // Empty lists, draining the pool, stealing the oldest full slot.
   task automatic test_directed();
      send_request(pbpm_pkg::OP_GET_FULL, 4'hF);
      for (int i = 0; i < POOL_SLOTS; i++) send_request(pbpm_pkg::OP_GET_EMPTY, 4'(i));
      send_request(pbpm_pkg::OP_GET_EMPTY, 4'h0);
      held_slots.delete();
      send_request(pbpm_pkg::OP_PUT_FULL, 4'h0);
      send_request(pbpm_pkg::OP_PUT_FULL, 4'hF);
      send_request(pbpm_pkg::OP_GET_EMPTY, 4'hA);
      send_request(pbpm_pkg::OP_GET_FULL, 4'h5);
      send_request(pbpm_pkg::OP_PUT_EMPTY, 4'h5);
      send_request(pbpm_pkg::OP_PUT_EMPTY, 4'hA);
      send_request(pbpm_pkg::OP_GET_EMPTY, 4'h3);
      // Slots the client holds after the sequence above.
      held_slots.delete();
      for (int i = 1; i < POOL_SLOTS - 1; i++) begin
         if (i != 5) held_slots.push_back(4'(i));
      end
      held_slots.push_back(4'h0);
      held_slots.push_back(4'hF);
   endtask

   // Gets and full puts outweigh empty puts, so the empty list runs dry.
   task automatic test_fill_and_steal();
      repeat (180) random_request(45, 10, 5, 35);
   endtask

   // Balanced traffic; the first stretch runs without any idling.
   task automatic test_steady_traffic();
      calm <= 1'b1;
      for (int n = 0; n < 250; n++) begin
         if (n == 120) calm <= 1'b0;
         random_request(30, 20, 20, 25);
      end
   endtask

   // Mostly noise: double puts and gets at random.
   task automatic test_double_puts();
      repeat (50) random_request(10, 10, 10, 10);
   endtask

   // The result side stalls at random except in the calm stretch.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Compare each result item with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      pool_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            $error("result item with none expected: slot_out %0d", rsp_tdata[3:0]);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[3:0] !== want.slot) begin
               $error("slot_out: expected %0d, actual %0d", want.slot, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== want.overwrote) begin
               $error("overwrote_full: expected %0d, actual %0d", want.overwrote,
                      rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      pool_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_steal();
      test_steady_traffic();
      test_double_puts();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
rtl/core/pbpm_pkg.sv
rtl/core/pbpm_ram.sv
rtl/core/pbpm_ctrl.sv
rtl/core/pbpm_datapath.sv
rtl/core/packet_buffer_pool_manager_unit.sv
dv/tb.sv
